/* hdl/assert_macros.svh */
// Assertion helper macros for the interval union table checks.
// No dependencies; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication on the same edge.
`define IUT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked on the next edge.
`define IUT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/iut_pkg.sv */
// Shared types and constants for the interval union table.
// No dependencies; used by controller, datapath, top level and checker.
package iut_pkg;

	localparam int CAPACITY_DEF    = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_REV  = 2'd2;

	localparam logic KIND_HIT = 1'b0;
	localparam logic KIND_SUM = 1'b1;

	localparam logic REQ_CLEAR = 1'b1;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       scan_eval;
		logic       bwd;
		logic       dec_bwd;
		logic       dec_fwd;
		logic       mv_wr;
		logic       wr_merge;
		logic       emit_sum;
		logic       sum_zero;
		logic [1:0] sum_stat;
	} iut_cmd_t;

	typedef struct packed {
		logic req_clear;
		logic req_rev;
		logic ptr_at_cnt;
		logic ptr_at_first;
		logic ev_hit;
		logic ev_past;
		logic out_free;
		logic hits_zero;
		logic full;
	} iut_sts_t;

endpackage

/* hdl/iut_datapath.sv */
// Datapath: interval table memory, scan/move pointers, merge registers
// and the output register. Depends on iut_pkg.
module iut_datapath import iut_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iut_cmd_t               cmd,
	output iut_sts_t               sts,
	input  logic                   in_clear,
	input  logic [VALUE_WIDTH-1:0] in_left,
	input  logic [VALUE_WIDTH-1:0] in_right,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_kind,
	output logic [VALUE_WIDTH-1:0] out_left,
	output logic [VALUE_WIDTH-1:0] out_right,
	output logic [1:0]             out_stat,
	output logic                   out_last
);
	localparam int IW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int DEPTH = 1 << IW;
	localparam int VW    = VALUE_WIDTH;

	logic [2*VW-1:0] mem [DEPTH];
	logic [2*VW-1:0] rd_q;
	logic [CW-1:0]   cnt_q, ptr_q, first_q, hits_q;
	logic [VW-1:0]   lo_q, hi_q, mlo_q, mhi_q;
	logic            ov_q;

	logic [VW-1:0]   rd_l, rd_r;
	logic [CW-1:0]   ptr_dec, dst_fwd;
	logic [IW-1:0]   rd_addr, wr_addr;
	logic            we;
	logic [2*VW-1:0] wd;
	logic            emit_hit, out_load;

	assign rd_l    = rd_q[VW-1:0];
	assign rd_r    = rd_q[2*VW-1:VW];
	assign ptr_dec = ptr_q - 1'b1;
	assign dst_fwd = ptr_q - hits_q + 1'b1;
	assign rd_addr = cmd.bwd ? ptr_dec[IW-1:0] : ptr_q[IW-1:0];

	assign we      = cmd.mv_wr || cmd.wr_merge;
	assign wr_addr = cmd.wr_merge ? first_q[IW-1:0] :
	                 (cmd.bwd ? ptr_q[IW-1:0] : dst_fwd[IW-1:0]);
	assign wd      = cmd.wr_merge ? {mhi_q, mlo_q} : rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		sts.req_clear    = (in_clear == REQ_CLEAR);
		sts.req_rev      = in_left > in_right;
		sts.ptr_at_cnt   = ptr_q == cnt_q;
		sts.ptr_at_first = ptr_q == first_q;
		sts.ev_hit       = (rd_l <= hi_q) && (rd_r >= lo_q);
		sts.ev_past      = rd_l > hi_q;
		sts.out_free     = !ov_q || out_ready;
		sts.hits_zero    = hits_q == '0;
		sts.full         = cnt_q == CW'(CAPACITY);
	end

	assign emit_hit = cmd.scan_eval && sts.ev_hit;
	assign out_load = emit_hit || cmd.emit_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ptr_q   <= '0;
			first_q <= '0;
			hits_q  <= '0;
		end else begin
			if (cmd.load) begin
				ptr_q  <= '0;
				hits_q <= '0;
			end
			if (cmd.clear) begin
				cnt_q <= '0;
			end
			if (cmd.scan_eval) begin
				if (sts.ev_hit) begin
					hits_q <= hits_q + 1'b1;
					if (sts.hits_zero) begin
						first_q <= ptr_q;
					end
					ptr_q <= ptr_q + 1'b1;
				end else if (!sts.ev_past) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			// no overlap: insertion point is where the scan stopped
			if (cmd.dec_bwd) begin
				first_q <= ptr_q;
				ptr_q   <= cnt_q;
			end
			if (cmd.dec_fwd) begin
				ptr_q <= first_q + hits_q;
			end
			if (cmd.mv_wr) begin
				ptr_q <= cmd.bwd ? ptr_dec : ptr_q + 1'b1;
			end
			if (cmd.wr_merge) begin
				cnt_q <= cmd.bwd ? cnt_q + 1'b1 : cnt_q - hits_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q  <= in_left;
			hi_q  <= in_right;
			mlo_q <= in_left;
			mhi_q <= in_right;
		end else if (emit_hit) begin
			if (rd_l < mlo_q) begin
				mlo_q <= rd_l;
			end
			if (rd_r > mhi_q) begin
				mhi_q <= rd_r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_hit) begin
			out_kind  <= KIND_HIT;
			out_left  <= rd_l;
			out_right <= rd_r;
			out_stat  <= STAT_OK;
			out_last  <= 1'b0;
		end else if (cmd.emit_sum) begin
			out_kind  <= KIND_SUM;
			out_left  <= cmd.sum_zero ? '0 : mlo_q;
			out_right <= cmd.sum_zero ? '0 : mhi_q;
			out_stat  <= cmd.sum_stat;
			out_last  <= 1'b1;
		end
	end

	assign out_valid = ov_q;

endmodule

/* hdl/iut_ctrl.sv */
// Controller FSM: sequences scan, shift and merge-write of one request.
// Depends on iut_pkg; drives iut_datapath through command/status structs.
module iut_ctrl import iut_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  iut_sts_t sts,
	output iut_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_SUM, S_SC_RD, S_SC_EV, S_DEC, S_MV_RD, S_MV_WR, S_MERGE
	} state_t;

	state_t     state_q;
	logic       ready_q, bwd_q, zero_q;
	logic [1:0] stat_q;
	logic       mv_done;

	assign in_ready = ready_q;
	assign mv_done  = bwd_q ? sts.ptr_at_first : sts.ptr_at_cnt;

	always_comb begin
		cmd          = '0;
		cmd.bwd      = bwd_q;
		cmd.sum_zero = zero_q;
		cmd.sum_stat = stat_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load  = in_valid;
				cmd.clear = in_valid && sts.req_clear;
			end
			S_SC_EV: cmd.scan_eval = sts.out_free || !sts.ev_hit;
			S_DEC: begin
				cmd.dec_bwd = sts.hits_zero && !sts.full;
				cmd.dec_fwd = !sts.hits_zero;
			end
			S_MV_WR: cmd.mv_wr    = 1'b1;
			S_MERGE: cmd.wr_merge = 1'b1;
			S_SUM:   cmd.emit_sum = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
			bwd_q   <= 1'b0;
			zero_q  <= 1'b0;
			stat_q  <= STAT_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ready_q <= 1'b0;
						bwd_q   <= 1'b0;
						zero_q  <= sts.req_clear;
						priority if (sts.req_clear) begin
							stat_q  <= STAT_OK;
							state_q <= S_SUM;
						end else if (sts.req_rev) begin
							stat_q  <= STAT_REV;
							state_q <= S_SUM;
						end else begin
							stat_q  <= STAT_OK;
							state_q <= S_SC_RD;
						end
					end
				end
				S_SUM: begin
					if (sts.out_free) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SC_RD: state_q <= sts.ptr_at_cnt ? S_DEC : S_SC_EV;
				S_SC_EV: begin
					// stall while a hit waits for the output register
					if (sts.out_free || !sts.ev_hit) begin
						state_q <= (sts.ev_past && !sts.ev_hit) ? S_DEC : S_SC_RD;
					end
				end
				S_DEC: begin
					if (sts.hits_zero && sts.full) begin
						stat_q  <= STAT_FULL;
						state_q <= S_SUM;
					end else begin
						bwd_q   <= sts.hits_zero;
						state_q <= S_MV_RD;
					end
				end
				S_MV_RD: state_q <= mv_done ? S_MERGE : S_MV_WR;
				S_MV_WR: state_q <= S_MV_RD;
				S_MERGE: state_q <= S_SUM;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hdl/interval_union_table_unit.sv */
// Top level of the interval union table: stream ports, controller, datapath.
// Depends on iut_pkg, iut_ctrl, iut_datapath.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser: req_type; tdata: left_end, right_end
//  m_axis    out  tvalid/tready, tlast   tuser: item_kind, status; tdata: out_left, out_right
//
// One request at a time; the input is ready only while idle.
// Clear and reversed requests go straight to the summary. Other requests scan the table
// one entry at a time, a read state then an evaluate state, up to the first entry past
// the interval; a dropped insert then ends. An insert shifts the tail through the table
// memory, a read state and a write state per entry, then writes the merged interval.
// Output stalls hold the scan and the summary. Reset empties the table at once; no clearing pass.
module interval_union_table_unit import iut_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int TDW = ((2 * VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [TDW-1:0] s_axis_tdata,  // left_end, right_end, zero pad
	input  logic [0:0]     s_axis_tuser,  // req_type
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [TDW-1:0] m_axis_tdata,  // out_left, out_right, zero pad
	output logic [2:0]     m_axis_tuser,  // item_kind, status[1:0]
	output logic           m_axis_tlast
);
	localparam int VW = VALUE_WIDTH;

	iut_cmd_t        cmd;
	iut_sts_t        sts;
	logic            out_kind, out_last;
	logic [VW-1:0]   out_left, out_right;
	logic [1:0]      out_stat;

	iut_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iut_datapath #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_clear  (s_axis_tuser[0]),
		.in_left   (s_axis_tdata[VW-1:0]),
		.in_right  (s_axis_tdata[2*VW-1:VW]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (out_kind),
		.out_left  (out_left),
		.out_right (out_right),
		.out_stat  (out_stat),
		.out_last  (out_last)
	);

	assign m_axis_tdata = TDW'({out_right, out_left});
	assign m_axis_tuser = {out_stat, out_kind};
	assign m_axis_tlast = out_last;

endmodule

/* hdl/iut_checker.sv */
// Port-level checks for interval_union_table_unit, bound to the top level.
// Depends on iut_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iut_checker import iut_pkg::*; #(
	parameter int TDW = 64
) (
	input logic           clk,
	input logic           arst_n,
	input logic           s_axis_tvalid,
	input logic           s_axis_tready,
	input logic           m_axis_tvalid,
	input logic           m_axis_tready,
	input logic [TDW-1:0] m_axis_tdata,
	input logic [2:0]     m_axis_tuser,
	input logic           m_axis_tlast
);

	`IUT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output changed while stalled")
	`IUT_ASSERT_NOW(a_last_is_sum, clk, arst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser[0] == KIND_SUM), "tlast does not match summary kind")
	`IUT_ASSERT_NOW(a_err_on_sum, clk, arst_n, m_axis_tvalid && (m_axis_tuser[2:1] != STAT_OK), (m_axis_tuser[0] == KIND_SUM) && m_axis_tlast, "error status on a non-summary transfer")
	`IUT_ASSERT_NEXT(a_one_req, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")

endmodule

bind interval_union_table_unit iut_checker #(.TDW(TDW)) u_iut_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
